>>> src/sdpd_pkg.sv
// Shared types and constants for the SMS-DELIVER PDU decoder.
// No dependencies; used by sms_deliver_pdu_decoder.
package sdpd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SCA     = 4'd1,
    PH_PDUTYPE = 4'd2,
    PH_OALEN   = 4'd3,
    PH_OATYPE  = 4'd4,
    PH_DIGITS  = 4'd5,
    PH_PID     = 4'd6,
    PH_DCS     = 4'd7,
    PH_SCTS    = 4'd8,
    PH_UDL     = 4'd9,
    PH_UCS2    = 4'd10,
    PH_GSM7    = 4'd11,
    PH_DONE    = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DIGIT  = 2'd0,
    KIND_SEPTET = 2'd1,
    KIND_UTF8   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  localparam int unsigned MAX_RES = 3;

  localparam logic [7:0]  DCS_UCS2     = 8'h08;
  localparam logic [7:0]  SCTS_LEN     = 8'd7;
  localparam logic [2:0]  SEPT_WRAP    = 3'd7;
  localparam logic [15:0] UTF8_1B_MAX  = 16'h007F;
  localparam logic [15:0] UTF8_2B_MAX  = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;

endpackage

>>> src/sms_deliver_pdu_decoder.sv
// SMS-DELIVER PDU decoder: octet stream in, sender digits / text symbols out.
// Depends on sdpd_pkg (phase and kind codes, result struct).
//
// Usage:
//   Input channel (in_*): one PDU octet per transaction in in_tdata; in_tuser
//   high marks the first octet (service-centre length) of a new PDU and
//   restarts decoding at once, dropping any PDU in progress.
//   Output channel (out_*): one result per transaction. out_tuser gives the
//   kind (sender digit, GSM septet, UTF-8 byte, empty text), out_tdata the
//   value and out_tlast flags the final result of the message text.
// Timing:
//   The decode state is updated in the accepting cycle and the results of
//   that octet land in a three-entry result register; the first one is shown
//   on the next cycle. An octet giving k results (0..3) occupies the result
//   register until all k are handed over, so with a ready receiver the block
//   takes one octet per cycle as long as octets give at most one result, and
//   an octet giving k > 1 results holds input off until one result is left.
//   A new octet is taken while the last pending result is being handed over.
// Reset: the block waits for a start-marked octet, result register empty.
// Stall: with out_tready low the results hold and in_tready drops once a
//   result is waiting.
module sms_deliver_pdu_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] octet
  input  logic       in_tuser,   // [0] start_req
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // last
);

  // decode state
  sdpd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] field_rem_r, field_rem_nxt;
  logic [7:0] digits_rem_r, digits_rem_nxt;
  logic       ucs2_r, ucs2_nxt;
  logic [7:0] text_rem_r, text_rem_nxt;
  logic [2:0] sept_ph_r, sept_ph_nxt;
  logic [6:0] carry_r, carry_nxt;
  logic [7:0] high_byte_r, high_byte_nxt;
  logic       high_pend_r, high_pend_nxt;

  // result register
  sdpd_pkg::res_t res_r [sdpd_pkg::MAX_RES];
  sdpd_pkg::res_t res_nxt [sdpd_pkg::MAX_RES];
  logic [1:0] cnt_r, cnt_nxt;

  logic in_acc, out_pop;

  assign out_pop    = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = res_r[0].value;
  assign out_tuser  = res_r[0].kind;
  assign out_tlast  = res_r[0].last;

  always_comb begin
    logic [7:0]  oct;
    logic [2:0]  p;
    logic [2:0]  shr;
    logic [14:0] wide;
    logic [6:0]  sept;
    logic [15:0] code;
    logic        fin;
    logic [1:0]  n;
    sdpd_pkg::phase_t ph;

    oct  = in_tdata;
    n    = 2'd0;
    p    = 3'd0;
    shr  = 3'd0;
    wide = 15'd0;
    sept = 7'd0;
    code = 16'd0;
    fin  = 1'b0;
    for (int i = 0; i < sdpd_pkg::MAX_RES; i++) begin
      res_nxt[i] = '{kind: sdpd_pkg::KIND_DIGIT, value: 8'd0, last: 1'b0};
    end

    if (in_tuser) begin
      ph             = sdpd_pkg::PH_SCA;
      field_rem_nxt  = 8'd0;
      digits_rem_nxt = 8'd0;
      ucs2_nxt       = 1'b0;
      text_rem_nxt   = 8'd0;
      sept_ph_nxt    = 3'd0;
      carry_nxt      = 7'd0;
      high_byte_nxt  = 8'd0;
      high_pend_nxt  = 1'b0;
    end else begin
      ph             = phase_r;
      field_rem_nxt  = field_rem_r;
      digits_rem_nxt = digits_rem_r;
      ucs2_nxt       = ucs2_r;
      text_rem_nxt   = text_rem_r;
      sept_ph_nxt    = sept_ph_r;
      carry_nxt      = carry_r;
      high_byte_nxt  = high_byte_r;
      high_pend_nxt  = high_pend_r;
    end
    phase_nxt = ph;

    unique case (ph)
      sdpd_pkg::PH_SCA: begin
        field_rem_nxt = oct;
        phase_nxt     = sdpd_pkg::PH_PDUTYPE;
      end
      sdpd_pkg::PH_PDUTYPE: begin
        // service-centre address octets, then the PDU type octet
        if (field_rem_nxt != 8'd0) field_rem_nxt = field_rem_nxt - 8'd1;
        else                       phase_nxt     = sdpd_pkg::PH_OALEN;
      end
      sdpd_pkg::PH_OALEN: begin
        digits_rem_nxt = oct;
        phase_nxt      = sdpd_pkg::PH_OATYPE;
      end
      sdpd_pkg::PH_OATYPE: begin
        phase_nxt = (digits_rem_nxt != 8'd0) ? sdpd_pkg::PH_DIGITS : sdpd_pkg::PH_PID;
      end
      sdpd_pkg::PH_DIGITS: begin
        if (digits_rem_nxt != 8'd0) begin
          res_nxt[n]     = '{kind: sdpd_pkg::KIND_DIGIT, value: {4'd0, oct[3:0]}, last: 1'b0};
          n              = n + 2'd1;
          digits_rem_nxt = digits_rem_nxt - 8'd1;
        end
        if (digits_rem_nxt != 8'd0) begin
          res_nxt[n]     = '{kind: sdpd_pkg::KIND_DIGIT, value: {4'd0, oct[7:4]}, last: 1'b0};
          n              = n + 2'd1;
          digits_rem_nxt = digits_rem_nxt - 8'd1;
        end
        if (digits_rem_nxt == 8'd0) phase_nxt = sdpd_pkg::PH_PID;
      end
      sdpd_pkg::PH_PID: begin
        phase_nxt = sdpd_pkg::PH_DCS;
      end
      sdpd_pkg::PH_DCS: begin
        ucs2_nxt      = (oct == sdpd_pkg::DCS_UCS2);
        field_rem_nxt = sdpd_pkg::SCTS_LEN;
        phase_nxt     = sdpd_pkg::PH_SCTS;
      end
      sdpd_pkg::PH_SCTS: begin
        if (field_rem_nxt != 8'd0) field_rem_nxt = field_rem_nxt - 8'd1;
        if (field_rem_nxt == 8'd0) phase_nxt     = sdpd_pkg::PH_UDL;
      end
      sdpd_pkg::PH_UDL: begin
        // UCS-2 length rounded down to whole units
        text_rem_nxt  = ucs2_nxt ? {oct[7:1], 1'b0} : oct;
        sept_ph_nxt   = 3'd0;
        carry_nxt     = 7'd0;
        high_pend_nxt = 1'b0;
        if (text_rem_nxt == 8'd0) begin
          res_nxt[0] = '{kind: sdpd_pkg::KIND_EMPTY, value: 8'd0, last: 1'b1};
          n          = 2'd1;
          phase_nxt  = sdpd_pkg::PH_DONE;
        end else begin
          phase_nxt = ucs2_nxt ? sdpd_pkg::PH_UCS2 : sdpd_pkg::PH_GSM7;
        end
      end
      sdpd_pkg::PH_UCS2: begin
        if (!high_pend_nxt) begin
          high_byte_nxt = oct;
          high_pend_nxt = 1'b1;
        end else begin
          code          = {high_byte_nxt, oct};
          high_pend_nxt = 1'b0;
          text_rem_nxt  = text_rem_nxt - 8'd2;
          fin           = (text_rem_nxt == 8'd0);
          if (code <= sdpd_pkg::UTF8_1B_MAX) begin
            res_nxt[0] = '{kind: sdpd_pkg::KIND_UTF8, value: code[7:0], last: fin};
            n          = 2'd1;
          end else if (code <= sdpd_pkg::UTF8_2B_MAX) begin
            res_nxt[0] = '{kind: sdpd_pkg::KIND_UTF8,
                           value: sdpd_pkg::UTF8_LEAD2 | {3'd0, code[10:6]}, last: 1'b0};
            res_nxt[1] = '{kind: sdpd_pkg::KIND_UTF8,
                           value: sdpd_pkg::UTF8_CONT | {2'd0, code[5:0]}, last: fin};
            n          = 2'd2;
          end else begin
            res_nxt[0] = '{kind: sdpd_pkg::KIND_UTF8,
                           value: sdpd_pkg::UTF8_LEAD3 | {4'd0, code[15:12]}, last: 1'b0};
            res_nxt[1] = '{kind: sdpd_pkg::KIND_UTF8,
                           value: sdpd_pkg::UTF8_CONT | {2'd0, code[11:6]}, last: 1'b0};
            res_nxt[2] = '{kind: sdpd_pkg::KIND_UTF8,
                           value: sdpd_pkg::UTF8_CONT | {2'd0, code[5:0]}, last: fin};
            n          = 2'd3;
          end
          if (fin) phase_nxt = sdpd_pkg::PH_DONE;
        end
      end
      sdpd_pkg::PH_GSM7: begin
        p    = (sept_ph_nxt == sdpd_pkg::SEPT_WRAP) ? 3'd0 : sept_ph_nxt;
        wide = {7'd0, oct} << p;
        sept = wide[6:0] | carry_nxt;
        shr  = sdpd_pkg::SEPT_WRAP - p;
        carry_nxt    = 7'(oct >> shr);
        p            = p + 3'd1;
        text_rem_nxt = text_rem_nxt - 8'd1;
        res_nxt[0]   = '{kind: sdpd_pkg::KIND_SEPTET, value: {1'b0, sept},
                         last: (text_rem_nxt == 8'd0)};
        n            = 2'd1;
        // every seventh octet completes an extra septet from the carry
        if ((text_rem_nxt != 8'd0) && (p == sdpd_pkg::SEPT_WRAP)) begin
          text_rem_nxt = text_rem_nxt - 8'd1;
          res_nxt[1]   = '{kind: sdpd_pkg::KIND_SEPTET, value: {1'b0, carry_nxt},
                           last: (text_rem_nxt == 8'd0)};
          n            = 2'd2;
        end
        if (p == sdpd_pkg::SEPT_WRAP) begin
          p         = 3'd0;
          carry_nxt = 7'd0;
        end
        sept_ph_nxt = p;
        if (text_rem_nxt == 8'd0) phase_nxt = sdpd_pkg::PH_DONE;
      end
      default: begin
        // idle or done: octet ignored
      end
    endcase
    cnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdpd_pkg::PH_IDLE;
      field_rem_r  <= 8'd0;
      digits_rem_r <= 8'd0;
      ucs2_r       <= 1'b0;
      text_rem_r   <= 8'd0;
      sept_ph_r    <= 3'd0;
      carry_r      <= 7'd0;
      high_byte_r  <= 8'd0;
      high_pend_r  <= 1'b0;
      cnt_r        <= 2'd0;
    end else begin
      if (in_acc) begin
        phase_r      <= phase_nxt;
        field_rem_r  <= field_rem_nxt;
        digits_rem_r <= digits_rem_nxt;
        ucs2_r       <= ucs2_nxt;
        text_rem_r   <= text_rem_nxt;
        sept_ph_r    <= sept_ph_nxt;
        carry_r      <= carry_nxt;
        high_byte_r  <= high_byte_nxt;
        high_pend_r  <= high_pend_nxt;
        cnt_r        <= cnt_nxt;
      end else if (out_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // result payload: loaded on an accepted transaction, shifted down on a pop
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < sdpd_pkg::MAX_RES; i++) res_r[i] <= res_nxt[i];
    end else if (out_pop) begin
      for (int i = 0; i < sdpd_pkg::MAX_RES - 1; i++) res_r[i] <= res_r[i+1];
    end
  end

endmodule
